@@ hdl/stit_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stit_pkg
// Shared types and constants of the square tone i2s transmitter.
// ----------------------------------------------------------------------------
package stit_pkg;

    localparam int DEF_SAMPLE_WIDTH = 16;

    localparam int FIELD_W    = 16;
    localparam int REM_W      = 10;                 // remainder of a divide by 1000
    localparam int DIVIDEND_W = FIELD_W + REM_W;    // widest dividend: rate * rem
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
    localparam int SECONDS_W  = 7;
    localparam int HALF_W     = 15;

    localparam logic [FIELD_W-1:0] MS_PER_SECOND  = 16'd1000;
    localparam logic [FIELD_W-1:0] RESET_SRATE    = 16'd48000;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    localparam logic CFG_SRATE  = 1'b0;
    localparam logic CFG_VOLUME = 1'b1;

    typedef enum logic [2:0] {
        SU_IDLE,
        SU_DUR,
        SU_MUL,
        SU_TAIL,
        SU_PER
    } setup_state_t;

    typedef struct packed {
        logic                 req_type;
        logic [FIELD_W-1:0]   frequency;
        logic [FIELD_W-1:0]   duration_ms;
    } in_t;

    typedef struct packed {
        logic bit_valid;
        logic frame_select;
        logic data_bit;
        logic last_bit;
        logic start_error;
    } out_t;

    typedef struct packed {
        logic [FIELD_W-1:0]   period;
        logic [HALF_W-1:0]    half;
        logic [SECONDS_W-1:0] seconds;
        logic [FIELD_W-1:0]   tail;
    } setup_t;

endpackage
`default_nettype wire

@@ hdl/square_tone_i2s_transmitter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// square_tone_i2s_transmitter
// Square-wave tone generator with a bit-serial i2s output.
// ----------------------------------------------------------------------------
// Each input word gives exactly one output word. A tick word sends one i2s
// bit while a tone plays, so ticks stream at one per clock while the output
// side keeps up. An accepted start word holds off the input while the shared
// one-bit-per-cycle divider runs three 26-bit divides in turn (duration into
// seconds, tail length, tone period) with a multiply state between the first
// two. A rejected start returns its error word without starting the setup.
module square_tone_i2s_transmitter #(
    parameter int SAMPLE_WIDTH = stit_pkg::DEF_SAMPLE_WIDTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire stit_pkg::in_t                in_data,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output stit_pkg::out_t                    out_data,
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_index,
    input  wire logic [stit_pkg::FIELD_W-1:0] cfg_wdata
);
    import stit_pkg::*;

    logic [FIELD_W-1:0] srate_reg, srate_next;
    logic [FIELD_W-1:0] volume_reg, volume_next;
    logic               out_valid_reg, out_valid_next;
    out_t               out_data_reg, out_data_next;

    logic               accept;
    logic               start_bad;
    logic               go;
    logic               tick;
    logic               setup_busy;
    logic               setup_load;
    setup_t             setup;
    logic               playing;
    out_t               tone_result;

    assign in_ready  = !setup_busy && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign start_bad = playing || (in_data.frequency == '0)
                     || (in_data.frequency > srate_reg);
    assign go        = accept && (in_data.req_type == REQ_START) && !start_bad;
    assign tick      = accept && (in_data.req_type == REQ_TICK);

    stit_setup u_setup (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (go),
        .srate       (srate_reg),
        .frequency   (in_data.frequency),
        .duration_ms (in_data.duration_ms),
        .busy        (setup_busy),
        .load        (setup_load),
        .setup       (setup)
    );

    stit_tone #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_tone (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (setup_load),
        .setup       (setup),
        .tick        (tick),
        .srate       (srate_reg),
        .volume      (volume_reg),
        .playing     (playing),
        .result      (tone_result)
    );

    always_comb
    begin
        srate_next  = srate_reg;
        volume_next = volume_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SRATE:  srate_next  = cfg_wdata;
                CFG_VOLUME: volume_next = cfg_wdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            if (in_data.req_type == REQ_TICK)
            begin
                out_data_next = tone_result;
            end
            else
            begin
                out_data_next             = '0;
                out_data_next.start_error = start_bad;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            srate_reg     <= RESET_SRATE;
            volume_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            srate_reg     <= srate_next;
            volume_reg    <= volume_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // no word is taken while the start sequence runs
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        setup_busy |-> !in_ready)
        else $error("input accepted during start setup");

    // new tone parameters only land while nothing is playing
    a_load_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        setup_load |-> !playing)
        else $error("tone setup loaded while playing");

    // the final bit of a tone closes the right slot
    a_last_on_right: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.last_bit) |-> (out_data.bit_valid && out_data.frame_select))
        else $error("last bit outside the right slot");

    // a bit word never carries a start error
    a_bit_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.bit_valid) |-> !out_data.start_error)
        else $error("start error on a bit word");

    // a rejected start leaves the tone state alone
    a_reject_no_setup: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_data.req_type == REQ_START) && start_bad) |=> !setup_busy)
        else $error("rejected start began setup");

endmodule
`default_nettype wire

@@ hdl/stit_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stit_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stit_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [stit_pkg::DIVIDEND_W-1:0] dividend,
    input  wire logic [stit_pkg::FIELD_W-1:0]    divisor,
    output logic                                 done,
    output logic      [stit_pkg::DIVIDEND_W-1:0] quotient,
    output logic      [stit_pkg::FIELD_W-1:0]    remainder
);
    import stit_pkg::*;

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [FIELD_W-1:0]    rem_reg, rem_next;
    logic [FIELD_W-1:0]    dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic [FIELD_W:0]      rem_sh;
    logic [FIELD_W:0]      rem_sub;
    logic                  ge;

    assign rem_sh  = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};
    assign ge      = rem_sh >= {1'b0, dsr_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = ge ? rem_sub[FIELD_W-1:0] : rem_sh[FIELD_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIVIDEND_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

@@ hdl/stit_setup.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stit_setup
// Start sequencer: whole seconds, tail length and tone period from a
// start word, through one shared serial divider.
// ----------------------------------------------------------------------------
module stit_setup (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         go,
    input  wire logic [stit_pkg::FIELD_W-1:0] srate,
    input  wire logic [stit_pkg::FIELD_W-1:0] frequency,
    input  wire logic [stit_pkg::FIELD_W-1:0] duration_ms,
    output logic                              busy,
    output logic                              load,
    output stit_pkg::setup_t                  setup
);
    import stit_pkg::*;

    setup_state_t          state_reg, state_next;
    logic [FIELD_W-1:0]    sr_reg, sr_next;
    logic [FIELD_W-1:0]    freq_reg, freq_next;
    logic [SECONDS_W-1:0]  secs_reg, secs_next;
    logic [REM_W-1:0]      msrem_reg, msrem_next;
    logic [FIELD_W-1:0]    tail_reg, tail_next;

    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [FIELD_W-1:0]    div_divisor;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_quo;
    logic [FIELD_W-1:0]    div_rem;
    logic [DIVIDEND_W-1:0] product;

    assign product = {{(DIVIDEND_W-FIELD_W){1'b0}}, sr_reg}
                   * {{(DIVIDEND_W-REM_W){1'b0}}, msrem_reg};

    stit_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next   = state_reg;
        sr_next      = sr_reg;
        freq_next    = freq_reg;
        secs_next    = secs_reg;
        msrem_next   = msrem_reg;
        tail_next    = tail_reg;
        div_start    = 1'b0;
        div_dividend = {{(DIVIDEND_W-FIELD_W){1'b0}}, duration_ms};
        div_divisor  = MS_PER_SECOND;
        load         = 1'b0;
        case (state_reg)
            SU_IDLE:
            begin
                if (go)
                begin
                    sr_next    = srate;
                    freq_next  = frequency;
                    div_start  = 1'b1;
                    state_next = SU_DUR;
                end
            end
            SU_DUR:
            begin
                if (div_done)
                begin
                    secs_next  = div_quo[SECONDS_W-1:0];
                    msrem_next = div_rem[REM_W-1:0];
                    state_next = SU_MUL;
                end
            end
            SU_MUL:
            begin
                // product lands in the divider's shift register
                div_start    = 1'b1;
                div_dividend = product;
                state_next   = SU_TAIL;
            end
            SU_TAIL:
            begin
                div_dividend = {{(DIVIDEND_W-FIELD_W){1'b0}}, sr_reg};
                div_divisor  = freq_reg;
                if (div_done)
                begin
                    tail_next  = div_quo[FIELD_W-1:0];
                    div_start  = 1'b1;
                    state_next = SU_PER;
                end
            end
            SU_PER:
            begin
                if (div_done)
                begin
                    load       = 1'b1;
                    state_next = SU_IDLE;
                end
            end
            default:
            begin
                state_next = SU_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SU_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg    <= sr_next;
        freq_reg  <= freq_next;
        secs_reg  <= secs_next;
        msrem_reg <= msrem_next;
        tail_reg  <= tail_next;
    end

    assign busy          = state_reg != SU_IDLE;
    assign setup.period  = div_quo[FIELD_W-1:0];
    assign setup.half    = div_quo[FIELD_W-1:1];
    assign setup.seconds = secs_reg;
    assign setup.tail    = tail_reg;

endmodule
`default_nettype wire

@@ hdl/stit_tone.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stit_tone
// Tone state and sample serializer: a rotating shift register sends each
// sample MSB first on the left slot and again on the right slot.
// ----------------------------------------------------------------------------
module stit_tone #(
    parameter int SAMPLE_WIDTH = stit_pkg::DEF_SAMPLE_WIDTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         load,
    input  wire stit_pkg::setup_t             setup,
    input  wire logic                         tick,
    input  wire logic [stit_pkg::FIELD_W-1:0] srate,
    input  wire logic [stit_pkg::FIELD_W-1:0] volume,
    output logic                              playing,
    output stit_pkg::out_t                    result
);
    import stit_pkg::*;

    localparam int BIT_IDX_W = $clog2(2 * SAMPLE_WIDTH);

    logic                    playing_reg, playing_next;
    logic [FIELD_W-1:0]      period_reg, period_next;
    logic [HALF_W-1:0]       half_reg, half_next;
    logic [FIELD_W-1:0]      phase_reg, phase_next;
    logic [FIELD_W-1:0]      sis_reg, sis_next;
    logic [SECONDS_W-1:0]    secs_reg, secs_next;
    logic [FIELD_W-1:0]      tail_reg, tail_next;
    logic [BIT_IDX_W-1:0]    bit_idx_reg, bit_idx_next;
    logic [SAMPLE_WIDTH-1:0] sample_reg, sample_next;

    logic [SAMPLE_WIDTH-1:0] vol_w;
    logic [SAMPLE_WIDTH-1:0] value;
    logic [SAMPLE_WIDTH-1:0] word;
    logic [FIELD_W:0]        phase_inc;
    logic [FIELD_W-1:0]      phase_adv;
    logic [FIELD_W-1:0]      sis_adv;
    logic [SECONDS_W-1:0]    secs_adv;
    logic                    second_end;
    logic                    sample_end;

    assign vol_w = SAMPLE_WIDTH'(volume);
    assign value = ({1'b0, phase_reg} < {2'b0, half_reg}) ? vol_w : ('0 - vol_w);
    // a new sample enters on the first bit of the left slot
    assign word  = (bit_idx_reg == '0) ? value : sample_reg;

    assign sample_end = bit_idx_reg == BIT_IDX_W'(2 * SAMPLE_WIDTH - 1);
    assign phase_inc  = {1'b0, phase_reg} + 1'b1;
    assign second_end = (secs_reg != '0) && ((sis_reg + 1'b1) >= srate);

    always_comb
    begin
        phase_adv = (phase_inc >= {1'b0, period_reg}) ? '0 : phase_inc[FIELD_W-1:0];
        sis_adv   = sis_reg + 1'b1;
        secs_adv  = secs_reg;
        if (second_end)
        begin
            // phase restarts at every whole second
            phase_adv = '0;
            sis_adv   = '0;
            secs_adv  = secs_reg - 1'b1;
        end
    end

    always_comb
    begin
        playing_next = playing_reg;
        period_next  = period_reg;
        half_next    = half_reg;
        phase_next   = phase_reg;
        sis_next     = sis_reg;
        secs_next    = secs_reg;
        tail_next    = tail_reg;
        bit_idx_next = bit_idx_reg;
        sample_next  = sample_reg;
        result       = '0;
        if (load)
        begin
            playing_next = (setup.seconds != '0) || (setup.tail != '0);
            period_next  = setup.period;
            half_next    = setup.half;
            secs_next    = setup.seconds;
            tail_next    = setup.tail;
            phase_next   = '0;
            sis_next     = '0;
            bit_idx_next = '0;
        end
        else if (tick && playing_reg)
        begin
            result.bit_valid    = 1'b1;
            result.frame_select = bit_idx_reg >= BIT_IDX_W'(SAMPLE_WIDTH);
            result.data_bit     = word[SAMPLE_WIDTH-1];
            sample_next         = {word[SAMPLE_WIDTH-2:0], word[SAMPLE_WIDTH-1]};
            bit_idx_next        = bit_idx_reg + 1'b1;
            if (sample_end)
            begin
                bit_idx_next = '0;
                phase_next   = phase_adv;
                sis_next     = sis_adv;
                secs_next    = secs_adv;
                if ((secs_adv == '0) && (sis_adv >= tail_reg))
                begin
                    playing_next    = 1'b0;
                    result.last_bit = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            playing_reg <= 1'b0;
            period_reg  <= '0;
            half_reg    <= '0;
            phase_reg   <= '0;
            sis_reg     <= '0;
            secs_reg    <= '0;
            tail_reg    <= '0;
            bit_idx_reg <= '0;
            sample_reg  <= '0;
        end
        else
        begin
            playing_reg <= playing_next;
            period_reg  <= period_next;
            half_reg    <= half_next;
            phase_reg   <= phase_next;
            sis_reg     <= sis_next;
            secs_reg    <= secs_next;
            tail_reg    <= tail_next;
            bit_idx_reg <= bit_idx_next;
            sample_reg  <= sample_next;
        end
    end

    assign playing = playing_reg;

endmodule
`default_nettype wire

@@ tb/sv/square_tone_i2s_transmitter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_tone_i2s_transmitter_tb
// Self-checking bench for the square tone i2s transmitter. A scoreboard class
// predicts the word for every accepted input word: start errors, idle ticks
// and the serial bits of each tone, with the phase restarting each second.
// Directed words hit the field extremes and the reject cases, then random
// phases change the registers between tones and play many short tones. Both
// handshakes stall at random, and the output side holds off once for a long
// stretch while ticks keep coming.
// ----------------------------------------------------------------------------
module square_tone_i2s_transmitter_tb;
    import stit_pkg::*;

    localparam int SW          = DEF_SAMPLE_WIDTH;
    localparam int BIT_POS_W   = $clog2(2 * SW);
    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 100;

    class tone_scoreboard;
        logic [FIELD_W-1:0]   rate;
        logic [FIELD_W-1:0]   vol;
        logic                 active;
        logic [FIELD_W-1:0]   period;
        logic [HALF_W-1:0]    half;
        logic [FIELD_W-1:0]   phase;
        logic [FIELD_W-1:0]   sample_pos;
        logic [SECONDS_W-1:0] secs_left;
        logic [FIELD_W-1:0]   tail;
        logic [BIT_POS_W-1:0] bit_pos;
        logic [SW-1:0]        sample;
        out_t                 bits_q[$];
        int                   errors;

        function new();
            rate       = RESET_SRATE;
            vol        = '0;
            active     = 1'b0;
            period     = '0;
            half       = '0;
            phase      = '0;
            sample_pos = '0;
            secs_left  = '0;
            tail       = '0;
            bit_pos    = '0;
            sample     = '0;
            errors     = 0;
        endfunction

        function void write_register(logic idx, logic [FIELD_W-1:0] val);
            if (idx == CFG_SRATE)
                rate = val;
            else
                vol = val;
        endfunction

        // step to the next sample, ends the tone once the tail is done
        function void next_sample();
            phase = phase + 1'b1;
            if (phase >= period)
                phase = '0;
            sample_pos = sample_pos + 1'b1;
            if (secs_left != 0 && sample_pos >= rate)
            begin
                sample_pos = '0;
                phase      = '0;
                secs_left  = secs_left - 1'b1;
            end
            if (secs_left == 0 && sample_pos >= tail)
                active = 1'b0;
        endfunction

        function void note_word(in_t w);
            out_t        o;
            logic [63:0] level;
            logic [31:0] rem_ms;
            o = '0;
            if (w.req_type == REQ_START)
            begin
                if (active || w.frequency == 0 || w.frequency > rate)
                    o.start_error = 1'b1;
                else
                begin
                    period     = rate / w.frequency;
                    half       = HALF_W'(period >> 1);
                    phase      = '0;
                    sample_pos = '0;
                    bit_pos    = '0;
                    sample     = '0;
                    secs_left  = SECONDS_W'(w.duration_ms / MS_PER_SECOND);
                    rem_ms     = 32'(w.duration_ms % MS_PER_SECOND);
                    tail       = FIELD_W'((32'(rate) * rem_ms) / 32'(MS_PER_SECOND));
                    active     = (secs_left != 0) || (tail != 0);
                end
            end
            else if (active)
            begin
                if (bit_pos == 0)
                begin
                    level  = (phase < FIELD_W'(half)) ? 64'(vol) : 64'(0) - 64'(vol);
                    sample = level[SW-1:0];
                end
                o.bit_valid    = 1'b1;
                o.frame_select = (bit_pos >= SW);
                o.data_bit     = sample[SW - 1 - (bit_pos % SW)];
                if (bit_pos == BIT_POS_W'(2 * SW - 1))
                begin
                    bit_pos = '0;
                    next_sample();
                    o.last_bit = !active;
                end
                else
                    bit_pos = bit_pos + 1'b1;
            end
            bits_q.push_back(o);
        endfunction

        function void check_field(string name, logic exp_v, logic act_v);
            if (exp_v !== act_v)
            begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_word(out_t got);
            out_t want;
            if (bits_q.size() == 0)
            begin
                $error("output word %b with no word expected", got);
                errors++;
                return;
            end
            want = bits_q.pop_front();
            check_field("bit_valid", want.bit_valid, got.bit_valid);
            check_field("frame_select", want.frame_select, got.frame_select);
            check_field("data_bit", want.data_bit, got.data_bit);
            check_field("last_bit", want.last_bit, got.last_bit);
            check_field("start_error", want.start_error, got.start_error);
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    in_t                in_data   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    out_t               out_data;
    logic               cfg_we    = 1'b0;
    logic               cfg_index = CFG_SRATE;
    logic [FIELD_W-1:0] cfg_wdata = '0;

    tone_scoreboard sb = new();
    int             word_count = 0;
    bit             quiet      = 1'b0;
    bit             steady     = 1'b0;
    bit             hold_req   = 1'b0;

    square_tone_i2s_transmitter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // output side: short stalls, calm stretches and one long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 63) == 0)
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(50, 200)) @(posedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_word(out_data);
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_word(input logic req, input logic [FIELD_W-1:0] freq,
                             input logic [FIELD_W-1:0] dur);
        in_t w;
        w.req_type    = req;
        w.frequency   = freq;
        w.duration_ms = dur;
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_word(w);
        word_count++;
    endtask

    task automatic send_tick();
        send_word(REQ_TICK, 16'($urandom), 16'($urandom));
    endtask

    task automatic maybe_pause();
        if (!quiet && !steady && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // stop sending and wait for every outstanding word
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.bits_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [FIELD_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.write_register(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int unsigned        r;
        int unsigned        f_hi;
        int unsigned        d_max;
        int                 base;
        int                 tones;
        int                 n_tones;
        bit                 cut;
        logic [FIELD_W-1:0] rate_v;
        logic [FIELD_W-1:0] vol_v;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: rejects, an empty tone and idle ticks
        send_word(REQ_TICK, 16'hFFFF, 16'hFFFF);
        send_word(REQ_START, 16'd0, 16'hFFFF);
        send_word(REQ_START, 16'd48001, 16'd0);
        send_word(REQ_START, 16'hFFFF, 16'h1234);
        send_word(REQ_START, 16'd48000, 16'd0);
        send_word(REQ_TICK, 16'h0000, 16'h0000);
        settle();

        // widest rate, only empty tones fit here
        write_reg(CFG_SRATE, 16'hFFFF);
        send_word(REQ_START, 16'hFFFF, 16'd0);
        send_word(REQ_START, 16'd1, 16'd0);
        settle();

        // slowest rate, full volume, a tone of two whole seconds
        write_reg(CFG_SRATE, 16'd1);
        write_reg(CFG_VOLUME, 16'hFFFF);
        send_word(REQ_START, 16'd2, 16'd5);
        send_word(REQ_START, 16'd1, 16'd2999);
        send_word(REQ_START, 16'd1, 16'd1000);
        repeat (4) send_tick();

        base  = word_count;
        tones = 0;
        while (word_count - base < 500 || tones < 8)
        begin
            settle();
            // a tone still running keeps a small rate so it ends soon
            if (sb.active)
                rate_v = 16'($urandom_range(1, 3));
            else
                case ($urandom_range(0, 9))
                    0:       rate_v = 16'hFFFF;
                    1:       rate_v = 16'($urandom_range(1, 65535));
                    2, 3:    rate_v = 16'($urandom_range(17, 2000));
                    default: rate_v = 16'($urandom_range(1, 16));
                endcase
            case ($urandom_range(0, 3))
                0:       vol_v = '0;
                1:       vol_v = '1;
                default: vol_v = 16'($urandom);
            endcase
            write_reg(CFG_SRATE, rate_v);
            write_reg(CFG_VOLUME, vol_v);
            if (base == word_count)
                hold_req = 1'b1;
            quiet   = (word_count - base >= 400) && (tones >= 6);
            steady  = quiet || ($urandom_range(0, 3) == 0);
            n_tones = $urandom_range(1, 4);
            cut     = 1'b0;
            for (int t = 0; t < n_tones && !cut; t++)
            begin
                if (!sb.active)
                begin
                    r = rate_v;
                    if ($urandom_range(0, 3) == 0)
                    begin
                        send_tick();
                        maybe_pause();
                    end
                    if ($urandom_range(0, 4) == 0)
                    begin
                        if (r == 65535 || $urandom_range(0, 1))
                            send_word(REQ_START, '0, 16'($urandom));
                        else
                            send_word(REQ_START, 16'($urandom_range(r + 1, 65535)),
                                      16'($urandom));
                        maybe_pause();
                    end
                    // keep tones to four samples at most
                    f_hi  = ($urandom_range(0, 1) || r < 4) ? r : 4;
                    d_max = (($urandom_range(0, 7) == 0) ? 4000 : 2000) / r;
                    send_word(REQ_START, 16'($urandom_range(1, f_hi)),
                              16'($urandom_range(0, d_max)));
                    maybe_pause();
                    if (sb.active)
                        tones++;
                end
                while (sb.active && !cut)
                begin
                    // a start word while playing must be rejected
                    if ($urandom_range(0, 15) == 0)
                        send_word(REQ_START, 16'($urandom), 16'($urandom));
                    else
                        send_tick();
                    maybe_pause();
                    cut = ($urandom_range(0, 99) == 0);
                end
                if (!cut && $urandom_range(0, 3) == 0)
                begin
                    send_tick();
                    maybe_pause();
                end
            end
        end

        quiet = 1'b1;
        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.bits_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/stit_pkg.sv
hdl/stit_div.sv
hdl/stit_setup.sv
hdl/stit_tone.sv
hdl/square_tone_i2s_transmitter.sv
tb/sv/square_tone_i2s_transmitter_tb.sv
